// ----- hw/rtl/alpha_band_bounding_boxes_macros.svh -----
// ----------------------------------------------------------------------------
// alpha_band_bounding_boxes_macros.svh
// Assertion macros shared by the band box modules.
// ----------------------------------------------------------------------------
`ifndef ALPHA_BAND_BOUNDING_BOXES_MACROS_SVH
`define ALPHA_BAND_BOUNDING_BOXES_MACROS_SVH

// same-cycle implication, checked outside reset
`define ABBB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ABBB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/abbb_pkg.sv -----
// ----------------------------------------------------------------------------
// abbb_pkg
// Types and constants for the alpha band bounding box block.
// ----------------------------------------------------------------------------
package abbb_pkg;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 25;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_AREA_THR     = 3'd2,
        CFG_ALPHA_THR    = 3'd3,
        CFG_FACE_ID      = 3'd4
    } t_cfg_index;

    // register reset values
    localparam logic [12:0] CFG_WIDTH_RST  = 13'd1024;
    localparam logic [12:0] CFG_HEIGHT_RST = 13'd1024;

    // largest size a 13-bit size register can hold
    localparam int CFG_SIZE_MAX = 8191;

    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [24:0] area_thr;
        logic [7:0]  alpha_thr;
        logic [3:0]  face_id;
    } t_cfg;

    // one result word
    typedef struct packed {
        logic [3:0]  box_face;
        logic [11:0] box_x;
        logic [11:0] box_y;
        logic [12:0] box_width;
        logic [12:0] box_height;
        logic [10:0] box_number;
        logic        is_summary;
        logic [11:0] box_count;
        logic        last_of_run;
    } t_result;

    // up to two results produced by one pixel, in order
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    // result queue
    localparam int RESULT_DEPTH = 8;
    localparam int PTR_W        = 3;
    localparam int CNT_W        = 4;
    localparam int PUSH_MAX     = 2;

endpackage

// ----- hw/rtl/alpha_band_bounding_boxes.sv -----
// ----------------------------------------------------------------------------
// alpha_band_bounding_boxes
// Finds bands of occupied rows in a stream of alpha bytes and reports the
// bounding box of each band plus a per-frame summary word.
// ----------------------------------------------------------------------------
//  channel  | handshake                 | payload
//  ---------+---------------------------+----------------------------------
//  pixel in | i_valid / o_stall         | i_alpha
//  result   | o_valid / i_stall         | o_box_* , o_is_summary, ...
//  config   | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One pixel per cycle while o_stall is low; a pixel is registered, then resolved
//  combinationally into zero, one or two words that go to an 8-word result queue.
//  A result word passes the pixel register and the result queue before it is output.
//  o_stall rises only when the queue could not absorb two more words from
//  each of the registered pixel and the incoming one (output held off).
//  Reset is synchronous; the config port is always ready.
// ----------------------------------------------------------------------------
module alpha_band_bounding_boxes #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel input
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_alpha,
    // result output
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [3:0]                       o_box_face,
    output logic [11:0]                      o_box_x,
    output logic [11:0]                      o_box_y,
    output logic [12:0]                      o_box_width,
    output logic [12:0]                      o_box_height,
    output logic [10:0]                      o_box_number,
    output logic                             o_is_summary,
    output logic [11:0]                      o_box_count,
    output logic                             o_last_of_run,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [abbb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [abbb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import abbb_pkg::*;

    t_cfg             r_cfg;
    t_push            w_push;
    t_result          w_head;
    logic [CNT_W-1:0] w_level;
    logic             w_busy;
    logic             w_accept;
    logic             w_pop;
    logic [CNT_W:0]   w_need;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width  <= CFG_WIDTH_RST;
            r_cfg.frame_height <= CFG_HEIGHT_RST;
            r_cfg.area_thr     <= '0;
            r_cfg.alpha_thr    <= '0;
            r_cfg.face_id      <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[12:0];
                CFG_FRAME_HEIGHT: r_cfg.frame_height <= i_cfg_data[12:0];
                CFG_AREA_THR:     r_cfg.area_thr     <= i_cfg_data[24:0];
                CFG_ALPHA_THR:    r_cfg.alpha_thr    <= i_cfg_data[7:0];
                CFG_FACE_ID:      r_cfg.face_id      <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // input flow control: room for two words from each pixel in flight
    always_comb begin
        w_need = (CNT_W+1)'(w_level) + (CNT_W+1)'(PUSH_MAX);
        if (w_busy) begin
            w_need = w_need + (CNT_W+1)'(PUSH_MAX);
        end
    end

    assign o_stall  = w_need > (CNT_W+1)'(RESULT_DEPTH);
    assign w_accept = i_valid && !o_stall;

    abbb_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_alpha  (i_alpha),
        .i_cfg    (r_cfg),
        .o_busy   (w_busy),
        .o_push   (w_push)
    );

    // result queue and output word
    assign o_valid = w_level != '0;
    assign w_pop   = o_valid && !i_stall;

    abbb_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_level (w_level)
    );

    assign o_box_face    = w_head.box_face;
    assign o_box_x       = w_head.box_x;
    assign o_box_y       = w_head.box_y;
    assign o_box_width   = w_head.box_width;
    assign o_box_height  = w_head.box_height;
    assign o_box_number  = w_head.box_number;
    assign o_is_summary  = w_head.is_summary;
    assign o_box_count   = w_head.box_count;
    assign o_last_of_run = w_head.last_of_run;

endmodule

// ----- hw/rtl/abbb_tracker.sv -----
// ----------------------------------------------------------------------------
// abbb_tracker
// Pixel register plus row / band tracking; emits box and summary words.
// ----------------------------------------------------------------------------
`include "alpha_band_bounding_boxes_macros.svh"

module abbb_tracker #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_alpha,
    input  abbb_pkg::t_cfg  i_cfg,
    output logic            o_busy,
    output abbb_pkg::t_push o_push
);
    import abbb_pkg::*;

    localparam int EFF_MAX_W = (MAX_WIDTH < CFG_SIZE_MAX) ? MAX_WIDTH : CFG_SIZE_MAX;
    localparam int EFF_MAX_H = (MAX_HEIGHT < CFG_SIZE_MAX) ? MAX_HEIGHT : CFG_SIZE_MAX;
    localparam int CW = $clog2(EFF_MAX_W);
    localparam int BW = $clog2(EFF_MAX_W + 1);
    localparam int RW = $clog2(EFF_MAX_H);
    localparam logic [12:0] W_CAP = 13'(EFF_MAX_W);
    localparam logic [12:0] H_CAP = 13'(EFF_MAX_H);
    localparam int RST_LEFT = (EFF_MAX_W < int'(CFG_WIDTH_RST)) ? EFF_MAX_W
                                                               : int'(CFG_WIDTH_RST);

    // pixel register
    logic          r_pix_valid;
    logic [7:0]    r_alpha;

    // frame state
    logic [CW-1:0] r_col,        n_col;
    logic [RW-1:0] r_row,        n_row;
    logic          r_row_occ,    n_row_occ;
    logic [CW-1:0] r_row_left,   n_row_left;
    logic [CW-1:0] r_row_right,  n_row_right;
    logic [BW-1:0] r_band_left,  n_band_left;
    logic [CW-1:0] r_band_right, n_band_right;
    logic [RW-1:0] r_band_start, n_band_start;
    logic          r_band_open,  n_band_open;
    logic [11:0]   r_emitted,    n_emitted;

    logic [12:0]   eff_w, eff_h;
    logic          occ, p_occ;
    logic [CW-1:0] p_left, p_right;
    logic [13:0]   col_inc, row_inc;
    logic          end_row, end_frame;
    logic [BW-1:0] upd_left, c_left;
    logic [CW-1:0] upd_right, c_right;
    logic [RW-1:0] c_start;
    logic [13:0]   c_w, c_h;
    logic [12:0]   box_w, box_h;
    logic [25:0]   area;
    logic          close_band, keep, summ;
    logic [11:0]   emitted_inc;
    t_result       box_res, sum_res;

    // clamped frame size
    always_comb begin
        if (i_cfg.frame_width == 13'd0) begin
            eff_w = 13'd1;
        end else if (i_cfg.frame_width > W_CAP) begin
            eff_w = W_CAP;
        end else begin
            eff_w = i_cfg.frame_width;
        end
        if (i_cfg.frame_height == 13'd0) begin
            eff_h = 13'd1;
        end else if (i_cfg.frame_height > H_CAP) begin
            eff_h = H_CAP;
        end else begin
            eff_h = i_cfg.frame_height;
        end
    end

    // row occupancy including the current pixel
    assign occ     = r_alpha > i_cfg.alpha_thr;
    assign p_occ   = r_row_occ | occ;
    assign p_left  = (occ && !r_row_occ) ? r_col : r_row_left;
    assign p_right = occ ? r_col : r_row_right;

    // position compares; a counter past a lowered size counts as the last
    assign col_inc   = 14'(r_col) + 14'd1;
    assign row_inc   = 14'(r_row) + 14'd1;
    assign end_row   = !(col_inc < 14'(eff_w));
    assign end_frame = !(row_inc < 14'(eff_h));

    // band extent after merging this row
    assign upd_left  = (BW'(p_left) < r_band_left) ? BW'(p_left) : r_band_left;
    assign upd_right = (p_right > r_band_right) ? p_right : r_band_right;

    // band being closed: by a blank row, or by the frame end inside a band
    assign c_left  = p_occ ? upd_left : r_band_left;
    assign c_right = p_occ ? upd_right : r_band_right;
    assign c_start = (p_occ && !r_band_open) ? r_row : r_band_start;
    assign c_h     = p_occ ? (row_inc - 14'(c_start)) : (14'(r_row) - 14'(r_band_start));
    assign c_w     = 14'(c_right) - 14'(c_left) + 14'd1;
    assign box_w   = 13'(c_w);
    assign box_h   = 13'(c_h);
    assign area    = 26'(box_w) * 26'(box_h);

    assign close_band  = r_pix_valid && end_row && (p_occ ? end_frame : r_band_open);
    assign keep        = close_band && (area > 26'(i_cfg.area_thr));
    assign summ        = r_pix_valid && end_row && end_frame;
    assign emitted_inc = r_emitted + 12'(keep);

    // result words
    always_comb begin
        box_res             = '0;
        box_res.box_face    = i_cfg.face_id;
        box_res.box_x       = 12'(c_left);
        box_res.box_y       = 12'(c_start);
        box_res.box_width   = box_w;
        box_res.box_height  = box_h;
        box_res.box_number  = r_emitted[10:0];
        box_res.last_of_run = !summ;

        sum_res             = '0;
        sum_res.is_summary  = 1'b1;
        sum_res.box_count   = emitted_inc;
        sum_res.last_of_run = 1'b1;
    end

    always_comb begin
        o_push.count  = 2'(keep) + 2'(summ);
        o_push.first  = keep ? box_res : sum_res;
        o_push.second = sum_res;
    end

    assign o_busy = r_pix_valid;

    // next frame state
    always_comb begin
        n_col        = r_col;
        n_row        = r_row;
        n_row_occ    = r_row_occ;
        n_row_left   = r_row_left;
        n_row_right  = r_row_right;
        n_band_left  = r_band_left;
        n_band_right = r_band_right;
        n_band_start = r_band_start;
        n_band_open  = r_band_open;
        n_emitted    = r_emitted;
        if (r_pix_valid) begin
            if (!end_row) begin
                n_col       = CW'(col_inc);
                n_row_occ   = p_occ;
                n_row_left  = p_left;
                n_row_right = p_right;
            end else if (end_frame) begin
                // frame done: back to reset values, band left at the frame width
                n_col        = '0;
                n_row        = '0;
                n_row_occ    = 1'b0;
                n_row_left   = '0;
                n_row_right  = '0;
                n_band_left  = BW'(eff_w);
                n_band_right = '0;
                n_band_start = '0;
                n_band_open  = 1'b0;
                n_emitted    = '0;
            end else begin
                n_col       = '0;
                n_row       = RW'(row_inc);
                n_row_occ   = 1'b0;
                n_row_left  = '0;
                n_row_right = '0;
                n_emitted   = emitted_inc;
                if (p_occ) begin
                    n_band_left  = upd_left;
                    n_band_right = upd_right;
                    n_band_start = c_start;
                    n_band_open  = 1'b1;
                end else if (r_band_open) begin
                    n_band_left  = BW'(eff_w);
                    n_band_right = '0;
                    n_band_open  = 1'b0;
                end
            end
        end
    end

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid  <= 1'b0;
            r_col        <= '0;
            r_row        <= '0;
            r_row_occ    <= 1'b0;
            r_row_left   <= '0;
            r_row_right  <= '0;
            r_band_left  <= BW'(RST_LEFT);
            r_band_right <= '0;
            r_band_start <= '0;
            r_band_open  <= 1'b0;
            r_emitted    <= '0;
        end else begin
            r_pix_valid  <= i_accept;
            r_col        <= n_col;
            r_row        <= n_row;
            r_row_occ    <= n_row_occ;
            r_row_left   <= n_row_left;
            r_row_right  <= n_row_right;
            r_band_left  <= n_band_left;
            r_band_right <= n_band_right;
            r_band_start <= n_band_start;
            r_band_open  <= n_band_open;
            r_emitted    <= n_emitted;
        end
    end

    // pixel payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_alpha <= i_alpha;
        end
    end

    // checks
    `ABBB_ASSERT_IMPL(a_pair_ends_in_summary, o_push.count == 2'd2, o_push.second.is_summary && !o_push.first.is_summary && !o_push.first.last_of_run, "two words must be a box then the summary")
    `ABBB_ASSERT_IMPL(a_band_ordered, r_band_open, r_band_left <= BW'(r_band_right), "open band has left past right")
    `ABBB_ASSERT_IMPL(a_row_ordered, r_row_occ, r_row_left <= r_row_right, "occupied row has left past right")
    `ABBB_ASSERT_NEXT(a_frame_cleared, summ, r_row == '0 && r_col == '0 && !r_band_open && r_emitted == '0, "frame state not cleared after summary")

endmodule

// ----- hw/rtl/abbb_result_fifo.sv -----
// ----------------------------------------------------------------------------
// abbb_result_fifo
// Small result queue: takes up to two words per cycle, gives one per cycle when popped.
// ----------------------------------------------------------------------------
`include "alpha_band_bounding_boxes_macros.svh"

module abbb_result_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  abbb_pkg::t_push            i_push,
    input  logic                       i_pop,
    output abbb_pkg::t_result          o_head,
    output logic [abbb_pkg::CNT_W-1:0] o_level
);
    import abbb_pkg::*;

    t_result          r_mem [RESULT_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wr_next;

    assign wr_next = r_wr + PTR_W'(1);

    // storage; second word lands right after the first
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(i_push.count);
            r_rd    <= r_rd + PTR_W'(i_pop);
            r_count <= r_count + CNT_W'(i_push.count) - CNT_W'(i_pop);
        end
    end

    assign o_head  = r_mem[r_rd];
    assign o_level = r_count;

    // checks
    `ABBB_ASSERT_IMPL(a_no_overflow, 1'b1, (CNT_W+1)'(r_count) + (CNT_W+1)'(i_push.count) - (CNT_W+1)'(i_pop) <= (CNT_W+1)'(RESULT_DEPTH), "result queue overflow")
    `ABBB_ASSERT_IMPL(a_no_underflow, i_pop, r_count != '0, "pop from empty result queue")
    `ABBB_ASSERT_IMPL(a_ptr_match, 1'b1, PTR_W'(r_wr - r_rd) == r_count[PTR_W-1:0], "pointers disagree with fill level")

endmodule
